### sv/ttlz_pkg.sv
// ----------------------------------------------------------------------------
// ttlz_pkg
// Shared types, codes and helpers for the text-token LZ copy decoder.
// ----------------------------------------------------------------------------
package ttlz_pkg;

    // History size in bytes and the derived address and count widths.
    localparam int unsigned HIST_DEPTH = 1048576;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
    localparam int unsigned CNT_W      = $clog2(HIST_DEPTH + 1);

    // Token characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        CMD_PRELOAD = 2'd0,
        CMD_STREAM  = 2'd1,
        CMD_DRAIN   = 2'd2,
        CMD_NEWFILE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_OUT = 2'd0,
        PH_POS = 2'd1,
        PH_LEN = 2'd2
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] in_byte;
    } req_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       copy_last;
    } rsp_item_t;

    // Action decided for one accepted item
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;      // literal byte, zero when not used
        logic               last;
        logic               from_mem;  // result byte comes from the history read
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
    } ttlz_act_t;

    // acc * 10 + d, saturating at the history depth
    function automatic logic [CNT_W-1:0] add_digit(input logic [CNT_W-1:0] acc,
                                                   input logic [3:0]       d);
        logic [CNT_W+3:0] wide;
        logic [CNT_W+3:0] t;
        wide = {4'b0000, acc};
        t = (wide << 3) + (wide << 1) + {{CNT_W{1'b0}}, d};
        if (t > (CNT_W + 4)'(HIST_DEPTH))
            return CNT_W'(HIST_DEPTH);
        return t[CNT_W-1:0];
    endfunction

endpackage

### sv/text_token_lz_copy_decoder.sv
// ----------------------------------------------------------------------------
// text_token_lz_copy_decoder
// Text-token LZ decoder: literals, '*pos len\n' match tokens and byte-wise
// copy drain over a growing byte history.
// ----------------------------------------------------------------------------
// Takes one item per clock unless req_stall is high and gives exactly one
// result item for each, via stage 1 and the output register. The
// history is a 1 MiB single-port-write, single-port-read RAM; every item
// makes at most one read (drain) and one write (preload, literal or drain),
// so the memory port pair sets the rate of one item per cycle. A drain reads
// the source byte in the accept cycle and writes it back as stage 1 moves on;
// when a copy overlaps its own output (source just behind the write point)
// the byte being written in the read cycle is forwarded to that read.
// Parser, write pointer, match base and pending copy live in flip-flops in
// ttlz_ctrl. The history needs no clearing after reset: only bytes already
// written are ever read. A result waits in an output register, and a new
// item is still taken while it waits as long as the middle stage is free.
// ----------------------------------------------------------------------------
module text_token_lz_copy_decoder import ttlz_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    logic       accept;
    ttlz_act_t  act;

    // stage 1: waiting on the history read
    logic       s1_valid_reg;
    ttlz_act_t  s1_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;
    logic       s1_move;

    // output register
    logic       out_valid_reg;
    rsp_item_t  out_reg;

    logic [7:0] ram_rdata;
    logic [7:0] mem_byte;
    logic [7:0] s1_byte;
    logic       ram_we;

    assign s1_move   = !out_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !s1_move;
    assign accept    = req_valid && !req_stall;

    ttlz_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (req_item),
        .act    (act)
    );

    // read-first RAM: a byte written in the read cycle comes from the bypass
    assign mem_byte = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign s1_byte  = s1_reg.from_mem ? mem_byte : s1_reg.data;
    assign ram_we   = s1_valid_reg && s1_move && s1_reg.wr_en;

    ttlz_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_reg.wr_addr),
        .wdata (s1_byte),
        .re    (accept && act.rd_en),
        .raddr (act.rd_addr),
        .rdata (ram_rdata)
    );

    // control of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= act;
            fwd_hit_reg  <= ram_we && (s1_reg.wr_addr == act.rd_addr);
            fwd_data_reg <= s1_byte;
        end
        if (s1_move)
        begin
            out_reg.kind      <= s1_reg.kind;
            // preload bytes go to the history only; the result byte stays zero
            out_reg.out_byte  <= (s1_reg.kind == KIND_DATA) ? s1_byte : 8'h00;
            out_reg.copy_last <= s1_reg.last;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

### sv/ttlz_ram.sv
// ----------------------------------------------------------------------------
// ttlz_ram
// Generic single-clock RAM, one write and one read port, registered read.
// Read-during-write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module ttlz_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/ttlz_ctrl.sv
// ----------------------------------------------------------------------------
// ttlz_ctrl
// Token parser, write pointer, match base and pending copy. Decides per item
// which history access to make and what result to give.
// ----------------------------------------------------------------------------
module ttlz_ctrl import ttlz_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  req_item_t item,
    output ttlz_act_t act
);

    logic [CNT_W-1:0] wc_reg,   wc_next;
    logic [CNT_W-1:0] base_reg, base_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] pos_reg,  pos_next;
    logic [CNT_W-1:0] len_reg,  len_next;
    logic [CNT_W-1:0] src_reg,  src_next;
    logic [CNT_W-1:0] rem_reg,  rem_next;

    logic             is_digit;
    logic [3:0]       digit_val;
    logic             pending;
    logic             full;
    logic [CNT_W:0]   src_sum;   // match_base + relative position
    logic [CNT_W:0]   end_wr;    // write_count + length
    logic [CNT_W:0]   end_src;   // source + length

    assign is_digit  = item.in_byte inside {[CH_ZERO:CH_NINE]};
    assign digit_val = 4'(item.in_byte - CH_ZERO);
    assign pending   = (rem_reg != '0);
    assign full      = (wc_reg >= CNT_W'(HIST_DEPTH));
    assign src_sum   = {1'b0, base_reg} + {1'b0, pos_reg};
    assign end_wr    = {1'b0, wc_reg} + {1'b0, len_reg};
    assign end_src   = src_sum + {1'b0, len_reg};

    always_comb
    begin
        wc_next    = wc_reg;
        base_next  = base_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;

        act.kind     = KIND_NONE;
        act.data     = 8'h00;
        act.last     = 1'b0;
        act.from_mem = 1'b0;
        act.rd_en    = 1'b0;
        act.rd_addr  = src_reg[HIST_AW-1:0];
        act.wr_en    = 1'b0;
        act.wr_addr  = wc_reg[HIST_AW-1:0];

        case (item.cmd)
            CMD_PRELOAD:
            begin
                if (pending || full)
                    act.kind = KIND_ERR;
                else
                begin
                    act.wr_en = 1'b1;
                    act.data  = item.in_byte;
                    wc_next   = wc_reg + 1'b1;
                end
            end
            CMD_STREAM:
            begin
                if (pending)
                    act.kind = KIND_ERR;
                else
                begin
                    case (phase_reg)
                        PH_POS:
                        begin
                            if (is_digit)
                                pos_next = add_digit(pos_reg, digit_val);
                            else if (item.in_byte == CH_SPACE)
                            begin
                                phase_next = PH_LEN;
                                len_next   = '0;
                            end
                        end
                        PH_LEN:
                        begin
                            if (is_digit)
                                len_next = add_digit(len_reg, digit_val);
                            else if (item.in_byte == CH_NL)
                            begin
                                phase_next = PH_OUT;
                                if (len_reg == '0)
                                begin
                                    if (src_sum > {1'b0, wc_reg})
                                        act.kind = KIND_ERR;
                                    else
                                        base_next = src_sum[CNT_W-1:0];
                                end
                                else if (src_sum >= {1'b0, wc_reg})
                                    act.kind = KIND_ERR;
                                else if (end_wr > (CNT_W + 1)'(HIST_DEPTH))
                                    act.kind = KIND_ERR;
                                else
                                begin
                                    src_next  = src_sum[CNT_W-1:0];
                                    rem_next  = len_reg;
                                    base_next = end_src[CNT_W-1:0];
                                end
                            end
                        end
                        PH_OUT:
                        begin
                            if (item.in_byte == CH_STAR)
                            begin
                                phase_next = PH_POS;
                                pos_next   = '0;
                            end
                            else if (full)
                                act.kind = KIND_ERR;
                            else
                            begin
                                act.kind  = KIND_DATA;
                                act.data  = item.in_byte;
                                act.wr_en = 1'b1;
                                wc_next   = wc_reg + 1'b1;
                            end
                        end
                        default:
                            phase_next = PH_OUT;
                    endcase
                end
            end
            CMD_DRAIN:
            begin
                if (pending && (src_reg < wc_reg) && !full)
                begin
                    act.kind     = KIND_DATA;
                    act.from_mem = 1'b1;
                    act.rd_en    = 1'b1;
                    act.wr_en    = 1'b1;
                    act.last     = (rem_reg == CNT_W'(1));
                    wc_next      = wc_reg + 1'b1;
                    src_next     = src_reg + 1'b1;
                    rem_next     = rem_reg - 1'b1;
                end
            end
            CMD_NEWFILE:
            begin
                base_next  = '0;
                phase_next = PH_OUT;
                pos_next   = '0;
                len_next   = '0;
                src_next   = '0;
                rem_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg    <= '0;
            base_reg  <= '0;
            phase_reg <= PH_OUT;
            pos_reg   <= '0;
            len_reg   <= '0;
            src_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (accept)
        begin
            wc_reg    <= wc_next;
            base_reg  <= base_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            src_reg   <= src_next;
            rem_reg   <= rem_next;
        end
    end

    // a copy only becomes pending on a completed token
    a_copy_outside_token: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> (phase_reg == PH_OUT))
        else $error("copy pending inside a token");

    a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= CNT_W'(HIST_DEPTH))
        else $error("write count beyond history depth");

    a_copy_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wc_reg} + {1'b0, rem_reg}) <= (CNT_W + 1)'(HIST_DEPTH))
        else $error("pending copy would overrun history");

    a_src_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> (src_reg < wc_reg))
        else $error("copy source not behind write pointer");

endmodule
